/* sv/drc_pkg.sv */
// Shared types and constants for the dirty rectangle coalescer.
// Used by drc_ctrl, drc_datapath and dirty_rect_coalescer; depends on nothing.
`timescale 1ns / 1ps

package drc_pkg;

    // default sizes handed to the top level parameters
    localparam int MAX_RECTS_DEF = 16;
    localparam int SCREEN_W_DEF  = 256;
    localparam int SCREEN_H_DEF  = 256;

    // fixed field widths
    localparam int AREA_W  = 21;
    localparam int SLACK_W = 16;
    localparam int COORD_W = 13;
    localparam int INDEX_W = 4;
    localparam int EDGE_W  = 9;
    localparam int COUNT_W = 5;

    localparam logic [SLACK_W-1:0] SLACK_RESET = 16'd380;

    // request opcodes
    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_MARK  = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    // result outcome codes
    localparam logic [1:0] RES_IGNORED  = 2'd0;
    localparam logic [1:0] RES_MERGED   = 2'd1;
    localparam logic [1:0] RES_APPENDED = 2'd2;
    localparam logic [1:0] RES_OTHER    = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic capture;   // latch the accepted request
        logic clip;      // register the clipped rectangle
        logic scan;      // issue list reads for the join cost scan
        logic commit;    // apply the operation to the list
        logic out_load;  // move the result into the output register
    } drc_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] op;
        logic       ignore;     // add is dropped (empty, off screen, whole screen)
        logic       scan_done;  // all entries issued and the cost pipe drained
        logic       out_free;   // output register can take a result
    } drc_status_t;

endpackage

/* sv/dirty_rect_coalescer.sv */
// Top level of the dirty rectangle coalescer: stream ports, payload packing,
// controller and datapath. Depends on drc_pkg, drc_ctrl and drc_datapath.
//
//  channel  | direction | handshake                      | payload
//  ---------+-----------+--------------------------------+-------------------------
//  s_axis   | in        | s_axis_tvalid / s_axis_tready  | tuser opcode, tdata rect
//  m_axis   | out       | m_axis_tvalid / m_axis_tready  | tuser outcome, tdata state
//  cfg      | in        | cfg_wr_en                      | cfg_wr_data join slack
//
// An add steps through capture, clip, a scan that reads the list one entry a cycle
// into a two stage join cost pipeline, drain check, commit and result. An empty
// list makes no reads; a dropped add goes from clip to result. Clear, mark and read
// step through capture, commit and result. One request is worked at a time; the next is
// taken while a result still waits in the output register. A stalled output holds
// the block in its last step. Reset is asynchronous, active low, with no clearing pass.
`timescale 1ns / 1ps

module dirty_rect_coalescer
#(
    parameter int MAX_RECTS = drc_pkg::MAX_RECTS_DEF,
    parameter int SCREEN_W  = drc_pkg::SCREEN_W_DEF,
    parameter int SCREEN_H  = drc_pkg::SCREEN_H_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // rect_x, rect_y, rect_w, rect_h, entry_index
    input  logic [1:0]  s_axis_tuser,   // opcode
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // entry_x0, entry_y0, entry_x1, entry_y1,
                                        // entry_count, whole_screen, total_area, zero pad
    output logic [1:0]  m_axis_tuser,   // outcome
    // join slack register
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);

    drc_pkg::drc_cmd_t    cmd;
    drc_pkg::drc_status_t status;

    logic [drc_pkg::EDGE_W-1:0]  out_x0, out_y0, out_x1, out_y1;
    logic [drc_pkg::COUNT_W-1:0] out_count;
    logic                        out_whole;
    logic [drc_pkg::AREA_W-1:0]  out_area;

    // sequencer
    drc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_op    (s_axis_tuser),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath
    drc_datapath
    #(
        .MAX_RECTS (MAX_RECTS),
        .SCREEN_W  (SCREEN_W),
        .SCREEN_H  (SCREEN_H)
    )
    u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_op       (s_axis_tuser),
        .in_x        (s_axis_tdata[12:0]),
        .in_y        (s_axis_tdata[25:13]),
        .in_w        (s_axis_tdata[38:26]),
        .in_h        (s_axis_tdata[51:39]),
        .in_index    (s_axis_tdata[55:52]),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_outcome (m_axis_tuser),
        .out_x0      (out_x0),
        .out_y0      (out_y0),
        .out_x1      (out_x1),
        .out_y1      (out_y1),
        .out_count   (out_count),
        .out_whole   (out_whole),
        .out_area    (out_area)
    );

    // result packing, lowest field first
    assign m_axis_tdata = {1'b0, out_area, out_whole, out_count,
                           out_y1, out_x1, out_y0, out_x0};

endmodule

/* sv/drc_ctrl.sv */
// Request sequencer for the dirty rectangle coalescer.
// Depends on drc_pkg (command and status structs, opcodes).
`timescale 1ns / 1ps

module drc_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [1:0]           in_op,
    output logic                 in_ready,
    input  drc_pkg::drc_status_t status,
    output drc_pkg::drc_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLIP,
        ST_SCAN,
        ST_COMMIT,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (in_op == drc_pkg::OP_ADD) ? ST_CLIP : ST_COMMIT;
                end
            end
            ST_CLIP:
            begin
                state_next = status.ignore ? ST_DONE : ST_SCAN;
            end
            ST_SCAN:
            begin
                if (status.scan_done)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // command decode
    always_comb
    begin
        in_ready       = (state_reg == ST_IDLE);
        cmd.capture    = (state_reg == ST_IDLE) && in_valid;
        cmd.clip       = (state_reg == ST_CLIP);
        cmd.scan       = (state_reg == ST_SCAN);
        cmd.commit     = (state_reg == ST_COMMIT);
        cmd.out_load   = (state_reg == ST_DONE) && status.out_free;
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* sv/drc_datapath.sv */
// Datapath of the dirty rectangle coalescer: request registers, clipper,
// rectangle list memory, join cost pipeline, list state and output register.
// Depends on drc_pkg (command and status structs, codes, widths).
`timescale 1ns / 1ps

module drc_datapath
#(
    parameter int MAX_RECTS = drc_pkg::MAX_RECTS_DEF,
    parameter int SCREEN_W  = drc_pkg::SCREEN_W_DEF,
    parameter int SCREEN_H  = drc_pkg::SCREEN_H_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    // request payload
    input  logic [1:0]                          in_op,
    input  logic signed [drc_pkg::COORD_W-1:0]  in_x,
    input  logic signed [drc_pkg::COORD_W-1:0]  in_y,
    input  logic signed [drc_pkg::COORD_W-1:0]  in_w,
    input  logic signed [drc_pkg::COORD_W-1:0]  in_h,
    input  logic [drc_pkg::INDEX_W-1:0]         in_index,
    // configuration
    input  logic                                cfg_wr_en,
    input  logic [drc_pkg::SLACK_W-1:0]         cfg_wr_data,
    // controller
    input  drc_pkg::drc_cmd_t                   cmd,
    output drc_pkg::drc_status_t                status,
    // result
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [1:0]                          out_outcome,
    output logic [drc_pkg::EDGE_W-1:0]          out_x0,
    output logic [drc_pkg::EDGE_W-1:0]          out_y0,
    output logic [drc_pkg::EDGE_W-1:0]          out_x1,
    output logic [drc_pkg::EDGE_W-1:0]          out_y1,
    output logic [drc_pkg::COUNT_W-1:0]         out_count,
    output logic                                out_whole,
    output logic [drc_pkg::AREA_W-1:0]          out_area
);

    localparam int IW     = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
    localparam int RCW    = $clog2(MAX_RECTS + 1);
    localparam int CW     = $clog2(SCREEN_W + 1);
    localparam int CHW    = $clog2(SCREEN_H + 1);
    localparam int EW     = 2 * CW + 2 * CHW;
    localparam int PW     = CW + CHW;
    localparam int CST_W  = (PW + 2 > drc_pkg::SLACK_W + 2) ? PW + 2 : drc_pkg::SLACK_W + 2;
    localparam int AREA_W = drc_pkg::AREA_W;
    localparam int CMPW   = RCW + drc_pkg::INDEX_W;
    localparam int EDGE_W = drc_pkg::EDGE_W;
    localparam int CLW    = drc_pkg::COORD_W + 1;

    localparam logic [AREA_W-1:0]    SCREEN_AREA = AREA_W'(SCREEN_W * SCREEN_H);
    localparam logic signed [CLW-1:0] SW_S       = CLW'(SCREEN_W);
    localparam logic signed [CLW-1:0] SH_S       = CLW'(SCREEN_H);
    localparam logic [RCW-1:0]       MAX_CNT     = RCW'(MAX_RECTS);

    // request registers
    logic [1:0]                         op_reg;
    logic signed [drc_pkg::COORD_W-1:0] x_reg, y_reg, w_reg, h_reg;
    logic [drc_pkg::INDEX_W-1:0]        idx_reg;

    // configuration and list state
    logic [drc_pkg::SLACK_W-1:0] slack_reg;
    logic [RCW-1:0]              count_reg;
    logic                        all_reg;
    logic [AREA_W-1:0]           area_reg;

    // clipped rectangle
    logic [CW-1:0]  nx0_reg, nx1_reg;
    logic [CHW-1:0] ny0_reg, ny1_reg;
    logic [PW-1:0]  na_reg;

    // scan pipeline
    logic [RCW-1:0]  scan_idx_reg;
    logic [EW-1:0]   rd_data_reg;
    logic            v1_reg, v2_reg;
    logic [IW-1:0]   idx1_reg, idx2_reg;
    logic [PW-1:0]   a_bb_reg, a_ea_reg;
    logic [EW-1:0]   a_box_reg;

    // best candidate
    logic                    found_reg;
    logic signed [CST_W-1:0] min_cost_reg;
    logic [IW-1:0]           best_idx_reg;
    logic [PW-1:0]           best_bb_reg, best_ea_reg;
    logic [EW-1:0]           best_box_reg;

    logic [1:0] outcome_reg;
    logic       rd_ok_reg;

    // output register
    logic                        out_valid_reg;
    logic [1:0]                  out_outcome_reg;
    logic [EDGE_W-1:0]           out_x0_reg, out_y0_reg, out_x1_reg, out_y1_reg;
    logic [drc_pkg::COUNT_W-1:0] out_count_reg;
    logic                        out_whole_reg;
    logic [AREA_W-1:0]           out_area_reg;

    // list memory, entry packed as {y1, x1, y0, x0}
    logic [EW-1:0] mem [MAX_RECTS];

    // ---------------------------------------------------------------
    // request capture and configuration
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= in_op;
            x_reg   <= in_x;
            y_reg   <= in_y;
            w_reg   <= in_w;
            h_reg   <= in_h;
            idx_reg <= in_index;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slack_reg <= drc_pkg::SLACK_RESET;
        end
        else if (cfg_wr_en)
        begin
            slack_reg <= cfg_wr_data;
        end
    end

    // ---------------------------------------------------------------
    // clip to the screen
    logic signed [CLW-1:0] xs, ys, xe, ye, x0c, y0c, x1c, y1c;
    logic                  clip_ign;

    always_comb
    begin
        xs  = {x_reg[drc_pkg::COORD_W-1], x_reg};
        ys  = {y_reg[drc_pkg::COORD_W-1], y_reg};
        xe  = xs + {w_reg[drc_pkg::COORD_W-1], w_reg};
        ye  = ys + {h_reg[drc_pkg::COORD_W-1], h_reg};
        x0c = (xs < 0) ? '0 : xs;
        y0c = (ys < 0) ? '0 : ys;
        x1c = (xe > SW_S) ? SW_S : xe;
        y1c = (ye > SH_S) ? SH_S : ye;
        clip_ign = all_reg || (w_reg <= 0) || (h_reg <= 0) || (x1c <= x0c) || (y1c <= y0c);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clip)
        begin
            nx0_reg <= x0c[CW-1:0];
            nx1_reg <= x1c[CW-1:0];
            ny0_reg <= y0c[CHW-1:0];
            ny1_reg <= y1c[CHW-1:0];
        end
        // area of the new rectangle, registered from the clipped edges in the cycle after the clip
        na_reg <= (nx1_reg - nx0_reg) * (ny1_reg - ny0_reg);
    end

    // ---------------------------------------------------------------
    // memory port: scan reads, entry read, merge or append write
    logic          issue, scan_more, rd_en;
    logic [IW-1:0] rd_addr;
    logic          full;
    logic          merge_ok;
    logic          mem_we;
    logic [IW-1:0] mem_wa;
    logic [EW-1:0] mem_wd;

    assign scan_more = (scan_idx_reg < count_reg);
    assign issue     = cmd.scan && scan_more;
    assign rd_en     = issue || (cmd.commit && (op_reg == drc_pkg::OP_READ));
    assign rd_addr   = issue ? scan_idx_reg[IW-1:0] : IW'(idx_reg);
    assign full      = (count_reg >= MAX_CNT);
    assign merge_ok  = found_reg
                       && ((min_cost_reg <= $signed(CST_W'(slack_reg))) || full);

    always_comb
    begin
        mem_we = cmd.commit && (op_reg == drc_pkg::OP_ADD) && (merge_ok || !full);
        mem_wa = merge_ok ? best_idx_reg : count_reg[IW-1:0];
        mem_wd = merge_ok ? best_box_reg : {ny1_reg, nx1_reg, ny0_reg, nx0_reg};
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // ---------------------------------------------------------------
    // cost stage A: bounding box and both areas
    logic [CW-1:0]  e_x0, e_x1, bx0, bx1;
    logic [CHW-1:0] e_y0, e_y1, by0, by1;
    logic [PW-1:0]  bb_area, e_area;

    always_comb
    begin
        e_x0 = rd_data_reg[CW-1:0];
        e_y0 = rd_data_reg[CW+CHW-1:CW];
        e_x1 = rd_data_reg[2*CW+CHW-1:CW+CHW];
        e_y1 = rd_data_reg[EW-1:2*CW+CHW];
        bx0  = (e_x0 < nx0_reg) ? e_x0 : nx0_reg;
        by0  = (e_y0 < ny0_reg) ? e_y0 : ny0_reg;
        bx1  = (e_x1 > nx1_reg) ? e_x1 : nx1_reg;
        by1  = (e_y1 > ny1_reg) ? e_y1 : ny1_reg;
        bb_area = (bx1 - bx0) * (by1 - by0);
        e_area  = (e_x1 - e_x0) * (e_y1 - e_y0);
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            idx1_reg <= scan_idx_reg[IW-1:0];
        end
        if (v1_reg)
        begin
            a_bb_reg  <= bb_area;
            a_ea_reg  <= e_area;
            a_box_reg <= {by1, bx1, by0, bx0};
            idx2_reg  <= idx1_reg;
        end
    end

    // cost stage B: extra area, keep the cheapest (first on ties)
    logic signed [CST_W-1:0] cost;
    logic                    take;

    assign cost = $signed(CST_W'(a_bb_reg) - CST_W'(a_ea_reg) - CST_W'(na_reg));
    assign take = v2_reg && (!found_reg || (cost < min_cost_reg));

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            min_cost_reg  <= cost;
            best_idx_reg  <= idx2_reg;
            best_bb_reg   <= a_bb_reg;
            best_ea_reg   <= a_ea_reg;
            best_box_reg  <= a_box_reg;
        end
    end

    // scan control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg <= '0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            found_reg    <= 1'b0;
        end
        else
        begin
            v1_reg <= issue;
            v2_reg <= v1_reg;
            if (cmd.capture)
            begin
                scan_idx_reg <= '0;
                found_reg    <= 1'b0;
            end
            else
            begin
                if (issue)
                begin
                    scan_idx_reg <= scan_idx_reg + 1'b1;
                end
                if (take)
                begin
                    found_reg <= 1'b1;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // list state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            all_reg   <= 1'b0;
            area_reg  <= '0;
        end
        else if (cmd.commit)
        begin
            case (op_reg)
                drc_pkg::OP_ADD:
                begin
                    if (merge_ok)
                    begin
                        area_reg <= area_reg + AREA_W'(best_bb_reg) - AREA_W'(best_ea_reg);
                    end
                    else if (!full)
                    begin
                        count_reg <= count_reg + 1'b1;
                        area_reg  <= area_reg + AREA_W'(na_reg);
                    end
                end
                drc_pkg::OP_CLEAR:
                begin
                    count_reg <= '0;
                    all_reg   <= 1'b0;
                    area_reg  <= '0;
                end
                drc_pkg::OP_MARK:
                begin
                    count_reg <= '0;
                    all_reg   <= 1'b1;
                    area_reg  <= SCREEN_AREA;
                end
                default:
                begin
                    count_reg <= count_reg;
                end
            endcase
        end
    end

    // outcome and read check
    always_ff @(posedge clk)
    begin
        if (cmd.clip)
        begin
            outcome_reg <= drc_pkg::RES_IGNORED;
        end
        else if (cmd.commit)
        begin
            if (op_reg == drc_pkg::OP_ADD)
            begin
                if (merge_ok)
                begin
                    outcome_reg <= drc_pkg::RES_MERGED;
                end
                else if (!full)
                begin
                    outcome_reg <= drc_pkg::RES_APPENDED;
                end
                else
                begin
                    outcome_reg <= drc_pkg::RES_IGNORED;
                end
            end
            else
            begin
                outcome_reg <= drc_pkg::RES_OTHER;
            end
            rd_ok_reg <= (CMPW'(idx_reg) < CMPW'(count_reg));
        end
    end

    // ---------------------------------------------------------------
    // output register
    logic show_entry;
    assign show_entry = (op_reg == drc_pkg::OP_READ) && rd_ok_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_outcome_reg <= outcome_reg;
            out_x0_reg      <= show_entry ? EDGE_W'(e_x0) : '0;
            out_y0_reg      <= show_entry ? EDGE_W'(e_y0) : '0;
            out_x1_reg      <= show_entry ? EDGE_W'(e_x1) : '0;
            out_y1_reg      <= show_entry ? EDGE_W'(e_y1) : '0;
            out_count_reg   <= drc_pkg::COUNT_W'(count_reg);
            out_whole_reg   <= all_reg;
            out_area_reg    <= area_reg;
        end
    end

    // status to the controller
    always_comb
    begin
        status.op        = op_reg;
        status.ignore    = clip_ign;
        status.scan_done = !scan_more && !v1_reg && !v2_reg;
        status.out_free  = !out_valid_reg || out_ready;
    end

    assign out_valid   = out_valid_reg;
    assign out_outcome = out_outcome_reg;
    assign out_x0      = out_x0_reg;
    assign out_y0      = out_y0_reg;
    assign out_x1      = out_x1_reg;
    assign out_y1      = out_y1_reg;
    assign out_count   = out_count_reg;
    assign out_whole   = out_whole_reg;
    assign out_area    = out_area_reg;

endmodule
